### sv/rex_pkg.sv
package rex_pkg;

  localparam int MAX_REPLICAS = 64;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 7;
  localparam int BETA_W       = 24;
  localparam int ENERGY_W     = 32;
  localparam int UNIFORM_BITS = 16;
  localparam int DIFF_W       = ENERGY_W + 1;
  localparam int PROD_W       = BETA_W + 1 + DIFF_W;
  localparam int DELTA_W      = PROD_W + 1;
  localparam int ACC_W        = 31;

  localparam logic [BETA_W-1:0] BETA_MAX = '1;

  localparam logic [63:0] EXP_ONE  = 64'd2147483648;
  localparam logic [63:0] EXP_STEP = 64'd2139111403;
  localparam int EXP_FINE_N   = 16;
  localparam int EXP_COARSE_N = 193;
  localparam int EXP_LAST     = 3072;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_BEGIN = 3'd2,
    OP_TRIAL = 3'd3,
    OP_READ  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2,
    ST_NOPAIR = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_BEGIN,
    S_RD,
    S_RD_OUT,
    S_OTHER,
    S_INIT_TOP,
    S_INIT_RUN,
    S_TR_MAP,
    S_TR_RD,
    S_TR_DIFF,
    S_TR_MUL,
    S_TR_SUB,
    S_TR_LUT,
    S_TR_EMUL,
    S_TR_DEC,
    S_TR_W1,
    S_TR_W2,
    S_TR_ADV,
    S_REF_A,
    S_REF_B,
    S_REF_C
  } state_t;

  typedef struct packed {
    logic    latch;
    logic    load_we;
    logic    begin_sweep;
    logic    init_setup;
    logic    init_write;
    logic    map_rd;
    logic    trial_rd;
    logic    diff;
    logic    mul;
    logic    sub;
    logic    lut;
    logic    emul;
    logic    decide;
    logic    swap_w1;
    logic    swap_w2;
    logic    advance;
    logic    ref_clr;
    logic    ref_rd_a;
    logic    ref_rd_b;
    logic    ref_wr;
    logic    rd_issue;
    logic    emit;
    logic    readout;
    logic    sweep_flag;
    status_t code;
  } rex_cmd_t;

  typedef struct packed {
    logic no_pair;
    logic accept;
    logic accepted;
    logic sweep_end;
    logic init_last;
    logic ref_last;
  } rex_sts_t;

  function automatic logic [EXP_COARSE_N*32-1:0] build_coarse();
    logic [63:0] t;
    logic [EXP_COARSE_N*32-1:0] tab;
    int k;
    t = EXP_ONE;
    tab = '0;
    tab[31:0] = t[31:0];
    for (k = 1; k <= EXP_LAST; k++) begin
      t = (t * EXP_STEP + (64'd1 << 30)) >> 31;
      if ((k & 15) == 0) begin
        tab[(k >> 4)*32 +: 32] = t[31:0];
      end
    end
    return tab;
  endfunction

  function automatic logic [EXP_FINE_N*32-1:0] build_fine();
    logic [63:0] t;
    logic [EXP_FINE_N*32-1:0] tab;
    int k;
    t = EXP_ONE;
    tab = '0;
    tab[31:0] = t[31:0];
    for (k = 1; k < EXP_FINE_N; k++) begin
      t = (t * EXP_STEP + (64'd1 << 30)) >> 31;
      tab[k*32 +: 32] = t[31:0];
    end
    return tab;
  endfunction

  localparam logic [EXP_COARSE_N*32-1:0] EXP_COARSE_TAB = build_coarse();
  localparam logic [EXP_FINE_N*32-1:0]   EXP_FINE_TAB   = build_fine();

  function automatic logic [31:0] exp_coarse(input logic [7:0] idx);
    logic [31:0] v;
    v = '0;
    if (int'(idx) < EXP_COARSE_N) begin
      v = EXP_COARSE_TAB[idx*32 +: 32];
    end
    return v;
  endfunction

  function automatic logic [31:0] exp_fine(input logic [3:0] idx);
    return EXP_FINE_TAB[idx*32 +: 32];
  endfunction

endpackage

### sv/rex_cfg.sv
module rex_cfg
  import rex_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic [CNT_W-1:0]    n_eff,
  output logic [BETA_W-1:0]   beta_low,
  output logic [BETA_W-1:0]   beta_step
);

  localparam logic [1:0] REG_NUM  = 2'd0;
  localparam logic [1:0] REG_LOW  = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;

  logic [CNT_W-1:0]  num_r;
  logic [BETA_W-1:0] low_r;
  logic [BETA_W-1:0] step_r;
  logic              wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r  <= CNT_W'(64);
      low_r  <= BETA_W'(1048576);
      step_r <= BETA_W'(16384);
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_NUM:  num_r  <= pwdata[CNT_W-1:0];
        REG_LOW:  low_r  <= pwdata[BETA_W-1:0];
        REG_STEP: step_r <= pwdata[BETA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_NUM:  prdata = 32'(num_r);
      REG_LOW:  prdata = 32'(low_r);
      REG_STEP: prdata = 32'(step_r);
      default:  prdata = '0;
    endcase
  end

  always_comb begin
    if (num_r < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (num_r > CNT_W'(MAX_REPLICAS)) begin
      n_eff = CNT_W'(MAX_REPLICAS);
    end else begin
      n_eff = num_r;
    end
  end

  assign beta_low  = low_r;
  assign beta_step = step_r;

endmodule

### sv/rex_ctrl.sv
module rex_ctrl
  import rex_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] in_opcode,
  input  rex_sts_t   sts,
  output rex_cmd_t   cmd,
  output logic       busy
);

  state_t state_r;
  state_t state_nxt;
  status_t trial_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign trial_code = sts.accepted ? ST_ACCEPT : ST_REJECT;

  always_comb begin
    cmd = '0;
    cmd.code = ST_DONE;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          unique case (opcode_t'(in_opcode))
            OP_INIT:  state_nxt = S_INIT_TOP;
            OP_LOAD:  state_nxt = S_LOAD;
            OP_BEGIN: state_nxt = S_BEGIN;
            OP_TRIAL: state_nxt = S_TR_MAP;
            OP_READ:  state_nxt = S_RD;
            default:  state_nxt = S_OTHER;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load_we = 1'b1;
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      S_BEGIN: begin
        cmd.begin_sweep = 1'b1;
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      S_OTHER: begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt = S_RD_OUT;
      end
      S_RD_OUT: begin
        cmd.emit = 1'b1;
        cmd.readout = 1'b1;
        state_nxt = S_IDLE;
      end
      S_INIT_TOP: begin
        cmd.init_setup = 1'b1;
        state_nxt = S_INIT_RUN;
      end
      S_INIT_RUN: begin
        cmd.init_write = 1'b1;
        if (sts.init_last) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TR_MAP: begin
        if (sts.no_pair) begin
          cmd.emit = 1'b1;
          cmd.code = ST_NOPAIR;
          state_nxt = S_IDLE;
        end else begin
          cmd.map_rd = 1'b1;
          state_nxt = S_TR_RD;
        end
      end
      S_TR_RD: begin
        cmd.trial_rd = 1'b1;
        state_nxt = S_TR_DIFF;
      end
      S_TR_DIFF: begin
        cmd.diff = 1'b1;
        state_nxt = S_TR_MUL;
      end
      S_TR_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_TR_SUB;
      end
      S_TR_SUB: begin
        cmd.sub = 1'b1;
        state_nxt = S_TR_LUT;
      end
      S_TR_LUT: begin
        cmd.lut = 1'b1;
        state_nxt = S_TR_EMUL;
      end
      S_TR_EMUL: begin
        cmd.emul = 1'b1;
        state_nxt = S_TR_DEC;
      end
      S_TR_DEC: begin
        cmd.decide = 1'b1;
        state_nxt = sts.accept ? S_TR_W1 : S_TR_ADV;
      end
      S_TR_W1: begin
        cmd.swap_w1 = 1'b1;
        state_nxt = S_TR_W2;
      end
      S_TR_W2: begin
        cmd.swap_w2 = 1'b1;
        state_nxt = S_TR_ADV;
      end
      S_TR_ADV: begin
        cmd.advance = 1'b1;
        if (sts.sweep_end) begin
          cmd.ref_clr = 1'b1;
          state_nxt = S_REF_A;
        end else begin
          cmd.emit = 1'b1;
          cmd.code = trial_code;
          state_nxt = S_IDLE;
        end
      end
      S_REF_A: begin
        cmd.ref_rd_a = 1'b1;
        state_nxt = S_REF_B;
      end
      S_REF_B: begin
        cmd.ref_rd_b = 1'b1;
        state_nxt = S_REF_C;
      end
      S_REF_C: begin
        cmd.ref_wr = 1'b1;
        if (sts.ref_last) begin
          cmd.emit = 1'b1;
          cmd.code = trial_code;
          cmd.sweep_flag = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_REF_A;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### sv/rex_dp.sv
module rex_dp
  import rex_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  rex_cmd_t                    cmd,
  output rex_sts_t                    sts,
  input  logic [CNT_W-1:0]            n_eff,
  input  logic [BETA_W-1:0]           beta_low,
  input  logic [BETA_W-1:0]           beta_step,
  input  logic [IDX_W-1:0]            in_rank,
  input  logic signed [ENERGY_W-1:0]  in_energy_own,
  input  logic signed [ENERGY_W-1:0]  in_energy_plus,
  input  logic signed [ENERGY_W-1:0]  in_energy_minus,
  input  logic                        in_direction,
  input  logic [UNIFORM_BITS-1:0]     in_uniform,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [BETA_W-1:0]           out_beta_value,
  output logic [IDX_W-1:0]            out_replica_index,
  output logic [BETA_W-1:0]           out_beta_plus,
  output logic [BETA_W-1:0]           out_beta_minus,
  output logic                        out_sweep_done
);

  localparam logic signed [DELTA_W-1:0] DELTA_MIN = -(DELTA_W'(12) << 32);

  function automatic logic [BETA_W-1:0] sat(input logic [ACC_W-1:0] v);
    return (v > ACC_W'(BETA_MAX)) ? BETA_MAX : v[BETA_W-1:0];
  endfunction

  logic [IDX_W-1:0]    rank_r;
  logic [ENERGY_W-1:0] eown_in_r, eplus_in_r, eminus_in_r;
  logic                dir_in_r;
  logic [UNIFORM_BITS-1:0] uni_r;

  logic [CNT_W-1:0] cursor_r;
  logic             dir_r;
  logic [IDX_W-1:0] cnt_r;
  logic [ACC_W-1:0] acc_r, top_r;
  logic [IDX_W-1:0] nm1, cur_i, inn, pn, pm;

  logic [IDX_W-1:0] roi_mem [MAX_REPLICAS];
  logic [IDX_W-1:0] ior_mem [MAX_REPLICAS];
  logic [BETA_W-1:0] beta_mem [MAX_REPLICAS];
  logic [BETA_W-1:0] bplus_mem [MAX_REPLICAS];
  logic [BETA_W-1:0] bminus_mem [MAX_REPLICAS];
  logic [ENERGY_W-1:0] eo_mem [MAX_REPLICAS];
  logic [ENERGY_W-1:0] ep_mem [MAX_REPLICAS];
  logic [ENERGY_W-1:0] em_mem [MAX_REPLICAS];

  logic [MAX_REPLICAS-1:0] roi_v_r, ior_v_r, beta_v_r, nb_v_r;

  logic [IDX_W-1:0] roi_ra, roi_rb, roi_wa, roi_wd;
  logic             roi_we;
  logic [IDX_W-1:0] roi_da_r, roi_db_r, roi_aa_r, roi_ab_r;
  logic             roi_va_r, roi_vb_r;
  logic [IDX_W-1:0] roi_a, roi_b;

  logic [IDX_W-1:0] ior_wa, ior_wd, ior_d_r;
  logic             ior_we, ior_dv_r;

  logic [IDX_W-1:0]  beta_ra, beta_wa;
  logic [BETA_W-1:0] beta_wd, beta_da_r, beta_db_r, beta_a, beta_b;
  logic              beta_we, beta_va_r, beta_vb_r;

  logic [IDX_W-1:0]  nb_wa;
  logic [BETA_W-1:0] nbp_wd, nbm_wd, bplus_d_r, bminus_d_r;
  logic              nb_we, nb_dv_r;

  logic [IDX_W-1:0]    ep_ra, em_ra;
  logic [ENERGY_W-1:0] eo_da_r, eo_db_r, ep_d_r, em_d_r, e_i_nn, e_nn_i;

  logic [IDX_W-1:0]  ri_r, rnn_r, inn_r;
  logic [BETA_W-1:0] bi_r, bnn_r;
  logic signed [DIFF_W-1:0]  d1_r, d2_r;
  logic signed [PROD_W-1:0]  p1_r, p2_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic [DELTA_W-1:0]        x;
  logic        pos_r, deep_r, acc_flag_r;
  logic [31:0] c_r, f_r;
  logic [63:0] eprod_r;
  logic [64:0] eround;
  logic [32:0] e_val;
  logic        accept;
  logic [BETA_W-1:0] init_plus, init_minus;

  assign nm1   = IDX_W'(n_eff - CNT_W'(1));
  assign cur_i = cursor_r[IDX_W-1:0];
  assign inn   = dir_r ? ((cur_i == '0) ? nm1 : cur_i - IDX_W'(1))
                       : ((cur_i == nm1) ? '0 : cur_i + IDX_W'(1));
  assign pn    = (cnt_r == nm1) ? '0 : cnt_r + IDX_W'(1);
  assign pm    = (cnt_r == '0) ? nm1 : cnt_r - IDX_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      rank_r      <= in_rank;
      eown_in_r   <= in_energy_own;
      eplus_in_r  <= in_energy_plus;
      eminus_in_r <= in_energy_minus;
      dir_in_r    <= in_direction;
      uni_r       <= in_uniform;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      dir_r    <= 1'b0;
    end else if (cmd.init_setup) begin
      cursor_r <= '0;
      dir_r    <= 1'b0;
    end else if (cmd.begin_sweep) begin
      cursor_r <= '0;
      dir_r    <= dir_in_r;
    end else if (cmd.advance) begin
      cursor_r <= cursor_r + CNT_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_setup || cmd.ref_clr) begin
      cnt_r <= '0;
    end else if (cmd.init_write || cmd.ref_wr) begin
      cnt_r <= cnt_r + IDX_W'(1);
    end
    if (cmd.init_setup) begin
      acc_r <= ACC_W'(beta_low);
      top_r <= ACC_W'(beta_low) + ACC_W'(nm1 * beta_step);
    end else if (cmd.init_write) begin
      acc_r <= acc_r + ACC_W'(beta_step);
    end
  end

  assign sts.no_pair   = (cursor_r >= n_eff);
  assign sts.sweep_end = ((cursor_r + CNT_W'(2)) >= n_eff);
  assign sts.init_last = (cnt_r == IDX_W'(MAX_REPLICAS - 1));
  assign sts.ref_last  = (cnt_r == nm1);
  assign sts.accept    = accept;
  assign sts.accepted  = acc_flag_r;

  // Index-to-rank map, two read ports.
  always_comb begin
    roi_ra = cur_i;
    roi_rb = inn;
    if (cmd.ref_rd_a) begin
      roi_ra = pn;
      roi_rb = pm;
    end else if (cmd.ref_rd_b) begin
      roi_ra = cnt_r;
    end
    roi_we = cmd.swap_w1 || cmd.swap_w2;
    roi_wa = cmd.swap_w1 ? cur_i : inn_r;
    roi_wd = cmd.swap_w1 ? rnn_r : ri_r;
  end

  always_ff @(posedge clk) begin
    if (roi_we) begin
      roi_mem[roi_wa] <= roi_wd;
    end
    roi_da_r <= roi_mem[roi_ra];
    roi_db_r <= roi_mem[roi_rb];
    roi_aa_r <= roi_ra;
    roi_ab_r <= roi_rb;
    roi_va_r <= roi_v_r[roi_ra];
    roi_vb_r <= roi_v_r[roi_rb];
  end

  assign roi_a = roi_va_r ? roi_da_r : roi_aa_r;
  assign roi_b = roi_vb_r ? roi_db_r : roi_ab_r;

  // Rank-to-index map.
  assign ior_we = cmd.swap_w1 || cmd.swap_w2;
  assign ior_wa = cmd.swap_w1 ? ri_r : rnn_r;
  assign ior_wd = cmd.swap_w1 ? inn_r : cur_i;

  always_ff @(posedge clk) begin
    if (ior_we) begin
      ior_mem[ior_wa] <= ior_wd;
    end
    ior_d_r  <= ior_v_r[rank_r] ? ior_mem[rank_r] : rank_r;
    ior_dv_r <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roi_v_r <= '0;
      ior_v_r <= '0;
    end else if (cmd.init_setup) begin
      roi_v_r <= '0;
      ior_v_r <= '0;
    end else begin
      if (roi_we) roi_v_r[roi_wa] <= 1'b1;
      if (ior_we) ior_v_r[ior_wa] <= 1'b1;
    end
  end

  // Beta by rank, two read ports.
  always_comb begin
    beta_ra = cmd.rd_issue ? rank_r : roi_a;
    beta_we = cmd.init_write || cmd.swap_w1 || cmd.swap_w2;
    if (cmd.init_write) begin
      beta_wa = cnt_r;
      beta_wd = sat(acc_r);
    end else if (cmd.swap_w1) begin
      beta_wa = ri_r;
      beta_wd = bnn_r;
    end else begin
      beta_wa = rnn_r;
      beta_wd = bi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (beta_we) begin
      beta_mem[beta_wa] <= beta_wd;
    end
    beta_da_r <= beta_mem[beta_ra];
    beta_db_r <= beta_mem[roi_b];
    beta_va_r <= beta_v_r[beta_ra];
    beta_vb_r <= beta_v_r[roi_b];
  end

  assign beta_a = beta_va_r ? beta_da_r : '0;
  assign beta_b = beta_vb_r ? beta_db_r : '0;

  // Neighbour betas.
  always_comb begin
    if (cnt_r == nm1) begin
      init_plus = beta_low;
    end else if (CNT_W'(cnt_r) < CNT_W'(nm1)) begin
      init_plus = sat(acc_r + ACC_W'(beta_step));
    end else begin
      init_plus = '0;
    end
    if (cnt_r == '0) begin
      init_minus = sat(top_r);
    end else if (CNT_W'(cnt_r) < n_eff) begin
      init_minus = sat(acc_r - ACC_W'(beta_step));
    end else begin
      init_minus = '0;
    end
    nb_we  = cmd.init_write || cmd.ref_wr;
    nb_wa  = cmd.init_write ? cnt_r : roi_a;
    nbp_wd = cmd.init_write ? init_plus : beta_a;
    nbm_wd = cmd.init_write ? init_minus : beta_b;
  end

  always_ff @(posedge clk) begin
    if (nb_we) begin
      bplus_mem[nb_wa]  <= nbp_wd;
      bminus_mem[nb_wa] <= nbm_wd;
    end
    bplus_d_r  <= bplus_mem[rank_r];
    bminus_d_r <= bminus_mem[rank_r];
    nb_dv_r    <= nb_v_r[rank_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_v_r <= '0;
      nb_v_r   <= '0;
    end else begin
      if (beta_we) beta_v_r[beta_wa] <= 1'b1;
      if (nb_we) nb_v_r[nb_wa] <= 1'b1;
    end
  end

  // Energies by rank.
  assign ep_ra = dir_r ? roi_b : roi_a;
  assign em_ra = dir_r ? roi_a : roi_b;

  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      eo_mem[rank_r] <= eown_in_r;
      ep_mem[rank_r] <= eplus_in_r;
      em_mem[rank_r] <= eminus_in_r;
    end
    eo_da_r <= eo_mem[roi_a];
    eo_db_r <= eo_mem[roi_b];
    ep_d_r  <= ep_mem[ep_ra];
    em_d_r  <= em_mem[em_ra];
  end

  assign e_i_nn = dir_r ? em_d_r : ep_d_r;
  assign e_nn_i = dir_r ? ep_d_r : em_d_r;

  // Trial arithmetic.
  assign x      = DELTA_W'(-delta_r);
  assign eround = {1'b0, eprod_r} + 65'(64'd1 << 30);
  assign e_val  = eround[63:31];
  assign accept = pos_r || (!deep_r &&
                  ((UNIFORM_BITS+33)'({uni_r, 31'd0}) < {e_val, UNIFORM_BITS'(0)}));

  always_ff @(posedge clk) begin
    if (cmd.map_rd) begin
      inn_r <= inn;
    end
    if (cmd.trial_rd) begin
      ri_r  <= roi_a;
      rnn_r <= roi_b;
    end
    if (cmd.diff) begin
      bi_r  <= beta_a;
      bnn_r <= beta_b;
      d1_r  <= $signed({eo_db_r[ENERGY_W-1], eo_db_r}) - $signed({e_i_nn[ENERGY_W-1], e_i_nn});
      d2_r  <= $signed({e_nn_i[ENERGY_W-1], e_nn_i}) - $signed({eo_da_r[ENERGY_W-1], eo_da_r});
    end
    if (cmd.mul) begin
      p1_r <= $signed({1'b0, bnn_r}) * d1_r;
      p2_r <= $signed({1'b0, bi_r}) * d2_r;
    end
    if (cmd.sub) begin
      delta_r <= $signed({p1_r[PROD_W-1], p1_r}) - $signed({p2_r[PROD_W-1], p2_r});
    end
    if (cmd.lut) begin
      pos_r  <= !delta_r[DELTA_W-1];
      deep_r <= (delta_r < DELTA_MIN);
      c_r    <= exp_coarse(x[35:28]);
      f_r    <= exp_fine(x[27:24]);
    end
    if (cmd.emul) begin
      eprod_r <= 64'(c_r) * 64'(f_r);
    end
    if (cmd.decide) begin
      acc_flag_r <= accept;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status     <= cmd.code;
      out_sweep_done <= cmd.sweep_flag;
      if (cmd.readout) begin
        out_beta_value    <= beta_a;
        out_replica_index <= ior_dv_r ? ior_d_r : '0;
        out_beta_plus     <= nb_dv_r ? bplus_d_r : '0;
        out_beta_minus    <= nb_dv_r ? bminus_d_r : '0;
      end else begin
        out_beta_value    <= '0;
        out_replica_index <= '0;
        out_beta_plus     <= '0;
        out_beta_minus    <= '0;
      end
    end
  end

endmodule

### sv/replica_exchange_swapper.sv
// Replica exchange swap engine for parallel tempering.
// Items enter on start while busy is low; opcode selects init, load energies,
// begin sweep, pair trial or read rank. Each item yields one result, shown for
// exactly one cycle with out_valid high; the receiver cannot hold it off.
// A pair trial reads the maps, the betas and the energies, forms the two
// energy multiplies and the exp table product, then decides; an accepted
// trial also writes the swap back to the maps and betas. The trial that
// ends a sweep then rebuilds the neighbour betas of all n ranks, one rank
// at a time. Init writes all 64 ranks in turn.
// busy falls in the cycle the result shows, so the next item can be taken
// while the result is on the outputs.
// Configuration is an APB port with num_replicas, beta_low and beta_step at
// byte addresses 0, 4 and 8; it should be written only while the block is idle.
// After reset betas read zero, the maps are the identity and a sweep to the
// right is open; no clearing pass is needed.
module replica_exchange_swapper
  import rex_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_opcode,
  input  logic [IDX_W-1:0]            in_rank,
  input  logic signed [ENERGY_W-1:0]  in_energy_own,
  input  logic signed [ENERGY_W-1:0]  in_energy_plus,
  input  logic signed [ENERGY_W-1:0]  in_energy_minus,
  input  logic                        in_direction,
  input  logic [UNIFORM_BITS-1:0]     in_uniform,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [BETA_W-1:0]           out_beta_value,
  output logic [IDX_W-1:0]            out_replica_index,
  output logic [BETA_W-1:0]           out_beta_plus,
  output logic [BETA_W-1:0]           out_beta_minus,
  output logic                        out_sweep_done,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  rex_cmd_t          cmd;
  rex_sts_t          sts;
  logic [CNT_W-1:0]  n_eff;
  logic [BETA_W-1:0] beta_low;
  logic [BETA_W-1:0] beta_step;

  rex_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .n_eff     (n_eff),
    .beta_low  (beta_low),
    .beta_step (beta_step)
  );

  rex_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  rex_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .n_eff             (n_eff),
    .beta_low          (beta_low),
    .beta_step         (beta_step),
    .in_rank           (in_rank),
    .in_energy_own     (in_energy_own),
    .in_energy_plus    (in_energy_plus),
    .in_energy_minus   (in_energy_minus),
    .in_direction      (in_direction),
    .in_uniform        (in_uniform),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_beta_value    (out_beta_value),
    .out_replica_index (out_replica_index),
    .out_beta_plus     (out_beta_plus),
    .out_beta_minus    (out_beta_minus),
    .out_sweep_done    (out_sweep_done)
  );

endmodule

### sv/rex_chk.sv
module rex_chk
  import rex_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [1:0]        out_status,
  input logic [BETA_W-1:0] out_beta_value,
  input logic [BETA_W-1:0] out_beta_plus,
  input logic              out_sweep_done
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("Accepted item did not raise busy.");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("Result shown without a preceding busy cycle.");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_beta_value == '0 && out_beta_plus == '0)
    else $error("Non-read result carries read fields.");

  a_sweep_trial: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sweep_done |-> out_status == ST_ACCEPT || out_status == ST_REJECT)
    else $error("Sweep end flagged on a result that is not a trial.");

endmodule

bind replica_exchange_swapper rex_chk u_chk (.*);

### dv/replica_exchange_swapper_tb.sv
`timescale 1ns / 1ps

module replica_exchange_swapper_tb;
  import rex_pkg::*;

  localparam int REG_NUM_REPLICAS = 0;
  localparam int REG_BETA_LOW     = 1;
  localparam int REG_BETA_STEP    = 2;
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
  localparam int IDLE_LIMIT   = 3000;
  localparam int RANDOM_ITEMS = 150;

  typedef struct {
    status_t           status;
    logic [BETA_W-1:0] beta_value;
    logic [IDX_W-1:0]  replica_index;
    logic [BETA_W-1:0] beta_plus;
    logic [BETA_W-1:0] beta_minus;
    logic              sweep_done;
  } swap_result_t;

  typedef struct {
    logic [2:0]          op;
    logic [IDX_W-1:0]    rank;
    logic [31:0]         e_own;
    logic [31:0]         e_plus;
    logic [31:0]         e_minus;
    logic                dir;
    logic [15:0]         unif;
    logic                typed;
    swap_result_t        res;
  } stim_row_t;

  logic clk, rst_n, start, busy;
  logic [2:0] in_opcode;
  logic [IDX_W-1:0] in_rank;
  logic signed [ENERGY_W-1:0] in_energy_own, in_energy_plus, in_energy_minus;
  logic in_direction;
  logic [UNIFORM_BITS-1:0] in_uniform;
  logic out_valid, out_sweep_done;
  logic [1:0] out_status;
  logic [BETA_W-1:0] out_beta_value, out_beta_plus, out_beta_minus;
  logic [IDX_W-1:0] out_replica_index;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  replica_exchange_swapper uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_rank(in_rank), .in_energy_own(in_energy_own),
    .in_energy_plus(in_energy_plus), .in_energy_minus(in_energy_minus),
    .in_direction(in_direction), .in_uniform(in_uniform),
    .out_valid(out_valid), .out_status(out_status), .out_beta_value(out_beta_value),
    .out_replica_index(out_replica_index), .out_beta_plus(out_beta_plus),
    .out_beta_minus(out_beta_minus), .out_sweep_done(out_sweep_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the ladder state.
  logic [CNT_W-1:0]  ladder_size;
  logic [BETA_W-1:0] ladder_low, ladder_step;
  logic [BETA_W-1:0] beta_of[MAX_REPLICAS];
  logic [BETA_W-1:0] beta_up_of[MAX_REPLICAS];
  logic [BETA_W-1:0] beta_down_of[MAX_REPLICAS];
  logic [IDX_W-1:0]  rank_at[MAX_REPLICAS];
  logic [IDX_W-1:0]  slot_of[MAX_REPLICAS];
  longint            en_own[MAX_REPLICAS];
  longint            en_up[MAX_REPLICAS];
  longint            en_down[MAX_REPLICAS];
  bit                loaded[MAX_REPLICAS];
  int                cursor;
  logic              sweep_left;
  logic [63:0]       decay_coarse[EXP_COARSE_N];
  logic [63:0]       decay_fine[EXP_FINE_N];

  swap_result_t pending_results[$];
  swap_result_t got;
  stim_row_t    stim_rows[$];
  int errors, checked, items_sent, idle_count;
  bit steady;

  function automatic int ladder_n();
    int n;
    n = ladder_size;
    if (n < 2) n = 2;
    if (n > MAX_REPLICAS) n = MAX_REPLICAS;
    return n;
  endfunction

  function automatic void build_decay();
    logic [63:0] t;
    t = 64'd2147483648;
    decay_coarse[0] = t;
    decay_fine[0] = t;
    for (int k = 1; k <= EXP_LAST; k++) begin
      t = (t * 64'd2139111403 + (64'd1 << 30)) >> 31;
      if (k < EXP_FINE_N) decay_fine[k] = t;
      if (k % 16 == 0) decay_coarse[k / 16] = t;
    end
  endfunction

  function automatic bit swap_wins(longint delta, logic [15:0] u);
    logic [63:0] x, q, e;
    if (delta >= 0) return 1'b1;
    if (delta < -(longint'(12) <<< 32)) return 1'b0;
    x = -delta;
    q = x >> 24;
    e = (decay_coarse[q >> 4] * decay_fine[q & 64'd15] + (64'd1 << 30)) >> 31;
    return ({48'd0, u} << 31) < (e << UNIFORM_BITS);
  endfunction

  function automatic void rebuild_neighbours(int n);
    for (int p = 0; p < n; p++) begin
      beta_up_of[rank_at[p]]   = beta_of[rank_at[(p + 1) % n]];
      beta_down_of[rank_at[p]] = beta_of[rank_at[(p + n - 1) % n]];
    end
  endfunction

  function automatic bit trial_has_energies();
    int n, partner;
    n = ladder_n();
    if (cursor >= n) return 1'b1;
    partner = sweep_left ? (cursor + n - 1) % n : (cursor + 1) % n;
    return loaded[rank_at[cursor]] && loaded[rank_at[partner]];
  endfunction

  function automatic swap_result_t predict_swap(stim_row_t r);
    swap_result_t res;
    int n, i, partner;
    logic [IDX_W-1:0] ri, rp;
    logic [BETA_W-1:0] tb;
    longint e_i_at_p, e_p_at_i, delta;
    res = '{ST_DONE, '0, '0, '0, '0, 1'b0};
    n = ladder_n();
    case (r.op)
      OP_INIT: begin
        for (int p = 0; p < MAX_REPLICAS; p++) begin
          longint b;
          b = longint'(ladder_low) + longint'(p) * longint'(ladder_step);
          rank_at[p] = p;
          slot_of[p] = p;
          beta_of[p] = (b > longint'(BETA_MAX)) ? BETA_MAX : b[BETA_W-1:0];
          beta_up_of[p] = '0;
          beta_down_of[p] = '0;
        end
        rebuild_neighbours(n);
        cursor = 0;
        sweep_left = 1'b0;
      end
      OP_LOAD: begin
        en_own[r.rank]  = longint'($signed(r.e_own));
        en_up[r.rank]   = longint'($signed(r.e_plus));
        en_down[r.rank] = longint'($signed(r.e_minus));
        loaded[r.rank]  = 1'b1;
      end
      OP_BEGIN: begin
        sweep_left = r.dir;
        cursor = 0;
      end
      OP_TRIAL: begin
        i = cursor;
        if (i >= n) begin
          res.status = ST_NOPAIR;
        end else begin
          partner = sweep_left ? (i + n - 1) % n : (i + 1) % n;
          ri = rank_at[i];
          rp = rank_at[partner];
          e_i_at_p = sweep_left ? en_down[ri] : en_up[ri];
          e_p_at_i = sweep_left ? en_up[rp] : en_down[rp];
          delta = longint'(beta_of[rp]) * (en_own[rp] - e_i_at_p)
                - longint'(beta_of[ri]) * (e_p_at_i - en_own[ri]);
          if (swap_wins(delta, r.unif)) begin
            slot_of[ri] = partner;
            slot_of[rp] = i;
            rank_at[i] = rp;
            rank_at[partner] = ri;
            tb = beta_of[ri];
            beta_of[ri] = beta_of[rp];
            beta_of[rp] = tb;
            res.status = ST_ACCEPT;
          end else begin
            res.status = ST_REJECT;
          end
          cursor = i + 2;
          if (cursor >= n) begin
            rebuild_neighbours(n);
            res.sweep_done = 1'b1;
          end
        end
      end
      OP_READ: begin
        res.beta_value = beta_of[r.rank];
        res.replica_index = slot_of[r.rank];
        res.beta_plus = beta_up_of[r.rank];
        res.beta_minus = beta_down_of[r.rank];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic stim_row_t mk(logic [2:0] op, logic [IDX_W-1:0] rank, logic [31:0] eo,
                                   logic [31:0] ep, logic [31:0] em, logic dir,
                                   logic [15:0] u, logic typed, swap_result_t res);
    stim_row_t r;
    r = '{op, rank, eo, ep, em, dir, u, typed, res};
    return r;
  endfunction

  function automatic logic [31:0] rand_energy();
    if ($urandom_range(7) == 0) return $urandom();
    return 32'($urandom_range(0, 32767)) - 32'd16384;
  endfunction

  task automatic send(stim_row_t r);
    swap_result_t p;
    if (!steady && $urandom_range(99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= r.op;
    in_rank <= r.rank;
    in_energy_own <= r.e_own;
    in_energy_plus <= r.e_plus;
    in_energy_minus <= r.e_minus;
    in_direction <= r.dir;
    in_uniform <= r.unif;
    do @(posedge clk); while (busy);
    p = predict_swap(r);
    pending_results.push_back(r.typed ? r.res : p);
    items_sent++;
  endtask

  task automatic write_reg(int idx, logic [31:0] value);
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_NUM_REPLICAS: ladder_size = value[CNT_W-1:0];
      REG_BETA_LOW:     ladder_low = value[BETA_W-1:0];
      default:          ladder_step = value[BETA_W-1:0];
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no item outstanding");
        errors++;
      end else begin
        got = pending_results.pop_front();
        checked++;
        if (out_status !== got.status) begin
          $error("status: expected %0d, got %0d", got.status, out_status);
          errors++;
        end
        if (out_beta_value !== got.beta_value) begin
          $error("beta_value: expected %0h, got %0h", got.beta_value, out_beta_value);
          errors++;
        end
        if (out_replica_index !== got.replica_index) begin
          $error("replica_index: expected %0d, got %0d", got.replica_index,
                 out_replica_index);
          errors++;
        end
        if (out_beta_plus !== got.beta_plus) begin
          $error("beta_plus: expected %0h, got %0h", got.beta_plus, out_beta_plus);
          errors++;
        end
        if (out_beta_minus !== got.beta_minus) begin
          $error("beta_minus: expected %0h, got %0h", got.beta_minus, out_beta_minus);
          errors++;
        end
        if (out_sweep_done !== got.sweep_done) begin
          $error("sweep_done: expected %0d, got %0d", got.sweep_done, out_sweep_done);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    swap_result_t zero_done, read63_reset, read0_init, read63_init;
    stim_row_t r;
    int n, op_pick, cfg_n[6], cfg_low[6], cfg_step[6];
    errors = 0;
    checked = 0;
    items_sent = 0;
    idle_count = 0;
    steady = 1'b0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_opcode <= OP_INIT;
    in_rank <= '0;
    in_energy_own <= '0;
    in_energy_plus <= '0;
    in_energy_minus <= '0;
    in_direction <= 1'b0;
    in_uniform <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    build_decay();
    ladder_size = 7'd64;
    ladder_low = 24'd1048576;
    ladder_step = 24'd16384;
    for (int p = 0; p < MAX_REPLICAS; p++) begin
      beta_of[p] = '0;
      beta_up_of[p] = '0;
      beta_down_of[p] = '0;
      rank_at[p] = p;
      slot_of[p] = p;
      loaded[p] = 1'b0;
      en_own[p] = 0;
      en_up[p] = 0;
      en_down[p] = 0;
    end
    cursor = 0;
    sweep_left = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    zero_done    = '{ST_DONE, '0, '0, '0, '0, 1'b0};
    read63_reset = '{ST_DONE, '0, 6'd63, '0, '0, 1'b0};
    read0_init   = '{ST_DONE, 24'd1048576, 6'd0, 24'd1064960, 24'd2080768, 1'b0};
    read63_init  = '{ST_DONE, 24'd2080768, 6'd63, 24'd1048576, 24'd2064384, 1'b0};
    stim_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 1, zero_done));
    stim_rows.push_back(mk(OP_READ, 63, 0, 0, 0, 0, 0, 1, read63_reset));
    stim_rows.push_back(mk(OP_FIRST_UNUSED, 63, '1, '1, '1, 1, '1, 1, zero_done));
    stim_rows.push_back(mk(OP_LAST_UNUSED, 0, 0, 0, 0, 0, 0, 1, zero_done));
    stim_rows.push_back(mk(OP_LOAD, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0, 1, zero_done));
    stim_rows.push_back(mk(OP_LOAD, 1, 32'h80000000, 32'hffffffff, 32'h7fffffff, 0, 0, 1,
                           zero_done));
    stim_rows.push_back(mk(OP_LOAD, 63, 0, 32'd4096, -32'sd4096, 0, 0, 1, zero_done));
    stim_rows.push_back(mk(OP_INIT, 0, 0, 0, 0, 0, 0, 1, zero_done));
    stim_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 1, read0_init));
    stim_rows.push_back(mk(OP_READ, 63, 0, 0, 0, 0, 0, 1, read63_init));
    stim_rows.push_back(mk(OP_TRIAL, 0, 0, 0, 0, 0, 16'h0000, 0, zero_done));
    stim_rows.push_back(mk(OP_BEGIN, 0, 0, 0, 0, 1, 0, 1, zero_done));
    stim_rows.push_back(mk(OP_TRIAL, 0, 0, 0, 0, 0, 16'hffff, 0, zero_done));
    stim_rows.push_back(mk(OP_LOAD, 2, 32'd4096, 32'd8192, 0, 0, 0, 1, zero_done));
    stim_rows.push_back(mk(OP_LOAD, 3, -32'sd8192, 32'd2048, 32'd12000, 0, 0, 1, zero_done));
    stim_rows.push_back(mk(OP_BEGIN, 0, 0, 0, 0, 0, 0, 1, zero_done));
    stim_rows.push_back(mk(OP_TRIAL, 0, 0, 0, 0, 0, 16'h8000, 0, zero_done));
    stim_rows.push_back(mk(OP_TRIAL, 0, 0, 0, 0, 0, 16'h0001, 0, zero_done));
    stim_rows.push_back(mk(OP_READ, 1, 0, 0, 0, 0, 0, 0, zero_done));
    stim_rows.push_back(mk(OP_READ, 2, 0, 0, 0, 0, 0, 0, zero_done));
    foreach (stim_rows[k]) send(stim_rows[k]);

    cfg_n    = '{64, 2, 3, 5, 17, 64};
    cfg_low  = '{1048576, 0, 24'hffffff, 24'h800000, 24'h012345, 24'hffffff};
    cfg_step = '{16384, 0, 24'hffffff, 24'h000100, 24'h0a0000, 0};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_NUM_REPLICAS, cfg_n[ph]);
      write_reg(REG_BETA_LOW, cfg_low[ph]);
      write_reg(REG_BETA_STEP, cfg_step[ph]);
      @(posedge clk);
      n = ladder_n();
      send(mk(OP_INIT, 0, 0, 0, 0, 0, 0, 0, zero_done));
      for (int rk = 0; rk < n; rk++) begin
        send(mk(OP_LOAD, rk, rand_energy(), rand_energy(), rand_energy(), 0, 0, 0, zero_done));
      end
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
        steady = (ph == 2);
        op_pick = $urandom_range(99);
        r = mk(OP_TRIAL, $urandom_range(63), rand_energy(), rand_energy(), rand_energy(),
               $urandom_range(1), $urandom_range(65535), 0, zero_done);
        if (op_pick < 20) r.op = OP_LOAD;
        else if (op_pick < 30) r.op = OP_BEGIN;
        else if (op_pick < 44) r.op = OP_READ;
        else if (op_pick < 47) r.op = OP_INIT;
        else if (op_pick < 49) r.op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        if (r.op == OP_LOAD && $urandom_range(1)) r.rank = $urandom_range(n - 1);
        if (r.op == OP_TRIAL && !trial_has_energies()) begin
          r.op = OP_LOAD;
          r.rank = loaded[rank_at[cursor]] ? rank_at[sweep_left ? (cursor + n - 1) % n
                                                                : (cursor + 1) % n]
                                           : rank_at[cursor];
        end
        send(r);
      end
      steady = 1'b0;
    end

    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (300) @(posedge clk);
    $display("Drove %0d items over six ladder settings; %0d results compared.",
             items_sent, checked);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
